/* rtl/smvg_pkg.sv */
`timescale 1ns / 1ps
// smvg_pkg: shared types and constants for the sphere mesh vertex generator
// no dependencies; used by every module under rtl/ except smvg_div
package smvg_pkg;

  localparam int COUNT_W    = 7;
  localparam int RADIUS_W   = 16;
  localparam int IDX_W      = 6;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_SEGMENT_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BAND_COUNT    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SPHERE_RADIUS = 2'd2;

  localparam int POS_W  = 18;
  localparam int NORM_W = 16;

  // Q30 cos, sin, unit coordinates; ring radius Q30 unsigned
  localparam int TRIG_W  = 32;
  localparam int RAD_W   = 31;
  localparam int ANGLE_W = 32;

  // square root operand and root
  localparam int SQ_IN_W = 62;
  localparam int SQ_RT_W = 31;

  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_W     = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [ANGLE_W-1:0] CORDIC_ATAN [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
    32'sd21354465,  32'sd10679838,  32'sd5340245,   32'sd2670163,  32'sd1335087,
    32'sd667544,    32'sd333772,    32'sd166886,    32'sd83443,    32'sd41722,
    32'sd20861,     32'sd10430,     32'sd5215,      32'sd2608,     32'sd1304
  };

  localparam int LIFT_Q8 = 2560;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  typedef enum logic [1:0] {
    KIND_BAD,
    KIND_TOP,
    KIND_BOTTOM,
    KIND_MIDDLE
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] band;
    logic [IDX_W-1:0] seg;
  } patch_t;

  typedef struct packed {
    logic                     seg_we;
    logic                     ring_we;
    logic signed [TRIG_W-1:0] co;
    logic signed [TRIG_W-1:0] si;
    logic signed [TRIG_W-1:0] uy;
    logic [RAD_W-1:0]         r;
  } tbl_wr_t;

endpackage

/* rtl/sphere_mesh_vertex_generator.sv */
`timescale 1ns / 1ps
// sphere_mesh_vertex_generator: top level, config registers and channel packing
// depends on smvg_pkg, smvg_build, smvg_front, smvg_back
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata: band_index[5:0], segment_index[11:6]
//  m_*       out  m_tvalid/m_tready  tdata: pos xyz, norm xyz; tlast; tuser bad
//  cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// a patch word yields one vertex word per cycle when the output is not stalled:
// six vertex words for a middle band, three for a cap, one for an out-of-range index
// from issue a vertex passes the table read, product, unit point and scaling stages to the output register
// after reset and after each write to segment_count or band_count the sine and
// ring tables are rebuilt by one shared serial divider, a square root unit and
// an iterative rotator; s_tready stays low meanwhile
// a four-deep patch queue lets input words arrive while the output is stalled
module sphere_mesh_vertex_generator #(
  parameter int MAX_DIVISIONS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [15:0]                        s_tdata,   // band_index, segment_index
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [103:0]                       m_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
  output logic                               m_tlast,   // last_vertex
  output logic                               m_tuser,   // bad_index
  input  logic                               cfg_we,
  input  logic [smvg_pkg::CFG_ADDR_W-1:0]    cfg_index,
  input  logic [smvg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW = $clog2(MAX_DIVISIONS+1);

  // configuration registers
  logic [smvg_pkg::COUNT_W-1:0]  segment_count;
  logic [smvg_pkg::COUNT_W-1:0]  band_count;
  logic [smvg_pkg::RADIUS_W-1:0] sphere_radius;

  // counts saturated at MAX_DIVISIONS
  logic [CW-1:0] nr, ns;

  logic                     kick, build_busy;
  smvg_pkg::tbl_wr_t        tbl_wr;
  logic [CW-1:0]            tbl_addr;
  logic                     q_valid, q_pop;
  smvg_pkg::patch_t         q_item;

  logic signed [smvg_pkg::POS_W-1:0]  pos_x, pos_y, pos_z;
  logic signed [smvg_pkg::NORM_W-1:0] norm_x, norm_y, norm_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= 7'd10;
      band_count    <= 7'd10;
      sphere_radius <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        smvg_pkg::REG_SEGMENT_COUNT: segment_count <= cfg_data[smvg_pkg::COUNT_W-1:0];
        smvg_pkg::REG_BAND_COUNT:    band_count    <= cfg_data[smvg_pkg::COUNT_W-1:0];
        smvg_pkg::REG_SPHERE_RADIUS: sphere_radius <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign nr = (32'(band_count) > 32'(MAX_DIVISIONS)) ? CW'(MAX_DIVISIONS) : CW'(band_count);
  assign ns = (32'(segment_count) > 32'(MAX_DIVISIONS)) ? CW'(MAX_DIVISIONS)
                                                        : CW'(segment_count);

  // a count change invalidates the tables
  assign kick = cfg_we && (cfg_index == smvg_pkg::REG_SEGMENT_COUNT ||
                           cfg_index == smvg_pkg::REG_BAND_COUNT);

  smvg_build #(.MAX_DIVISIONS(MAX_DIVISIONS)) u_build (
    .clk    (clk),
    .rst    (rst),
    .kick   (kick),
    .nr     (nr),
    .ns     (ns),
    .busy   (build_busy),
    .wr     (tbl_wr),
    .wr_addr(tbl_addr)
  );

  smvg_front #(.MAX_DIVISIONS(MAX_DIVISIONS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .band    (s_tdata[5:0]),
    .seg     (s_tdata[11:6]),
    .nr      (nr),
    .ns      (ns),
    .hold    (build_busy || cfg_we),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  smvg_back #(.MAX_DIVISIONS(MAX_DIVISIONS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .nr         (nr),
    .radius     (sphere_radius),
    .wr         (tbl_wr),
    .wr_addr    (tbl_addr),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .norm_x     (norm_x),
    .norm_y     (norm_y),
    .norm_z     (norm_z),
    .last_vertex(m_tlast),
    .bad_index  (m_tuser)
  );

  // fields from the lowest bit up, two pad bits on top
  assign m_tdata = {2'b00, norm_z, norm_y, norm_x, pos_z, pos_y, pos_x};

endmodule

/* rtl/smvg_div.sv */
`timescale 1ns / 1ps
// smvg_div: restoring divider, one quotient bit per cycle
// standalone; used by smvg_build
module smvg_div #(
  parameter int NUM_W = 60,
  parameter int DEN_W = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] work;
  logic [DEN_W-1:0] dvs;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, work[NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign quo   = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= num;
      dvs  <= den;
      rem  <= '0;
    end else if (busy) begin
      rem  <= fits ? DEN_W'(trial - {1'b0, dvs}) : trial[DEN_W-1:0];
      work <= {work[NUM_W-2:0], fits};
    end
  end

endmodule

/* rtl/smvg_isqrt.sv */
`timescale 1ns / 1ps
// smvg_isqrt: floor square root, one root bit (two operand bits) per cycle
// depends on smvg_pkg; used by smvg_build
module smvg_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [smvg_pkg::SQ_IN_W-1:0]  val,
  output logic [smvg_pkg::SQ_RT_W-1:0]  root,
  output logic                          done
);

  localparam int RW    = smvg_pkg::SQ_RT_W;
  localparam int IW    = smvg_pkg::SQ_IN_W;
  localparam int CNT_W = $clog2(RW);

  logic [IW-1:0]    work;
  logic [RW+1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [RW+3:0]    trial_rem;
  logic [RW+3:0]    trial;
  logic             fits;

  assign trial_rem = {rem, work[IW-1:IW-2]};
  assign trial     = {2'b00, root, 2'b01};
  assign fits      = trial_rem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(RW-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= val;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rem  <= fits ? (RW+2)'(trial_rem - trial) : trial_rem[RW+1:0];
      root <= {root[RW-2:0], fits};
      work <= {work[IW-3:0], 2'b00};
    end
  end

endmodule

/* rtl/smvg_build.sv */
`timescale 1ns / 1ps
// smvg_build: fills the segment (cos, sin) and ring (y, radius) tables
// depends on smvg_pkg, smvg_div, smvg_isqrt; used by the top level
module smvg_build #(
  parameter int MAX_DIVISIONS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    kick,
  input  logic [$clog2(MAX_DIVISIONS+1)-1:0] nr,
  input  logic [$clog2(MAX_DIVISIONS+1)-1:0] ns,
  output logic                    busy,
  output smvg_pkg::tbl_wr_t       wr,
  output logic [$clog2(MAX_DIVISIONS+1)-1:0] wr_addr
);

  localparam int CW    = $clog2(MAX_DIVISIONS+1);
  localparam int NUM_W = 2*CW + 46;
  localparam int DEN_W = 2*CW;
  localparam int QW    = 2*CW + 2;
  localparam int TW    = smvg_pkg::TRIG_W;
  localparam int XW    = smvg_pkg::CORDIC_W;
  localparam int AW    = smvg_pkg::ANGLE_W;
  localparam int KW    = $clog2(smvg_pkg::CORDIC_STEPS);
  localparam logic [KW-1:0] K_LAST = KW'(smvg_pkg::CORDIC_STEPS-1);

  typedef enum logic [2:0] {
    B_IDLE,
    B_LAUNCH,
    B_SEG_DIV,
    B_SEG_ROT,
    B_RING_YDIV,
    B_RING_TDIV,
    B_RING_SQRT
  } bstate_t;

  bstate_t state;
  logic [CW-1:0] idx;

  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_quo;
  logic             div_done;

  logic                         sqrt_start;
  logic [smvg_pkg::SQ_IN_W-1:0] sqrt_in;
  logic [smvg_pkg::SQ_RT_W-1:0] sqrt_root;
  logic                         sqrt_done;

  logic signed [XW-1:0] cx, cy, nx, ny, sx, sy;
  logic signed [AW-1:0] cz, nz;
  logic [KW-1:0]        k;
  logic [1:0]           quad;
  logic signed [TW-1:0] co_q, si_q;

  logic [smvg_pkg::RAD_W-1:0] ym;
  logic                       y_neg;

  function automatic logic [NUM_W-1:0] seg_num(input logic [CW-1:0] j,
                                              input logic [CW-1:0] n);
    return (NUM_W'(j) << 32) + NUM_W'(n >> 1);
  endfunction

  function automatic logic [NUM_W-1:0] y_num(input logic [CW-1:0] i,
                                            input logic [CW-1:0] n);
    logic signed [CW+1:0] d;
    logic [CW+1:0]        a;
    d = $signed({2'b00, n}) - $signed({1'b0, i, 1'b0});
    a = d < 0 ? (CW+2)'(-d) : (CW+2)'(d);
    return NUM_W'(a) << 30;
  endfunction

  function automatic logic [NUM_W-1:0] t_num(input logic [CW-1:0] i,
                                            input logic [CW-1:0] n);
    logic [QW-1:0] q;
    q = (QW'(i) * QW'(n - i)) << 2;
    return NUM_W'(q) << 46;
  endfunction

  smvg_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .quo  (div_quo),
    .done (div_done)
  );

  smvg_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sqrt_start),
    .val  (sqrt_in),
    .root (sqrt_root),
    .done (sqrt_done)
  );

  // one rotation step
  always_comb begin
    sx = cx >>> k;
    sy = cy >>> k;
    if (!cz[AW-1]) begin
      nx = cx - sy;
      ny = cy + sx;
      nz = cz - smvg_pkg::CORDIC_ATAN[k];
    end else begin
      nx = cx + sy;
      ny = cy - sx;
      nz = cz + smvg_pkg::CORDIC_ATAN[k];
    end
  end

  // quadrant fold-back of the final step
  always_comb begin
    case (quad)
      2'd0: begin co_q = TW'(nx);  si_q = TW'(ny);  end
      2'd1: begin co_q = TW'(-ny); si_q = TW'(nx);  end
      2'd2: begin co_q = TW'(-nx); si_q = TW'(-ny); end
      default: begin co_q = TW'(ny); si_q = TW'(-nx); end
    endcase
  end

  assign y_neg = {1'b0, idx, 1'b0} > {2'b00, nr};
  assign busy  = state != B_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_LAUNCH;
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
      wr.seg_we  <= 1'b0;
      wr.ring_we <= 1'b0;
      idx        <= '0;
    end else begin
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
      wr.seg_we  <= 1'b0;
      wr.ring_we <= 1'b0;
      if (kick) begin
        state <= B_LAUNCH;
      end else begin
        case (state)
          B_IDLE: begin
          end
          B_LAUNCH: begin
            idx       <= '0;
            div_num   <= seg_num('0, ns);
            div_den   <= DEN_W'(ns);
            div_start <= 1'b1;
            state     <= B_SEG_DIV;
          end
          B_SEG_DIV: begin
            if (div_done && !div_start) begin
              cx    <= smvg_pkg::CORDIC_GAIN;
              cy    <= '0;
              cz    <= $signed({2'b00, div_quo[29:0]});
              quad  <= div_quo[31:30];
              k     <= '0;
              state <= B_SEG_ROT;
            end
          end
          B_SEG_ROT: begin
            cx <= nx;
            cy <= ny;
            cz <= nz;
            k  <= k + 1'b1;
            if (k == K_LAST) begin
              wr.seg_we <= 1'b1;
              wr.co     <= co_q;
              wr.si     <= si_q;
              wr_addr   <= idx;
              div_start <= 1'b1;
              if (idx == ns) begin
                idx     <= '0;
                div_num <= y_num('0, nr);
                div_den <= DEN_W'(nr);
                state   <= B_RING_YDIV;
              end else begin
                idx     <= idx + 1'b1;
                div_num <= seg_num(idx + 1'b1, ns);
                div_den <= DEN_W'(ns);
                state   <= B_SEG_DIV;
              end
            end
          end
          B_RING_YDIV: begin
            if (div_done && !div_start) begin
              ym        <= div_quo[smvg_pkg::RAD_W-1:0];
              div_num   <= t_num(idx, nr);
              div_den   <= DEN_W'(nr) * DEN_W'(nr);
              div_start <= 1'b1;
              state     <= B_RING_TDIV;
            end
          end
          B_RING_TDIV: begin
            if (div_done && !div_start) begin
              sqrt_in    <= {1'b0, div_quo[46:0], 14'b0};
              sqrt_start <= 1'b1;
              state      <= B_RING_SQRT;
            end
          end
          B_RING_SQRT: begin
            if (sqrt_done && !sqrt_start) begin
              wr.ring_we <= 1'b1;
              wr.uy      <= y_neg ? -TW'(ym) : TW'(ym);
              wr.r       <= sqrt_root;
              wr_addr    <= idx;
              if (idx == nr) begin
                state <= B_IDLE;
              end else begin
                idx       <= idx + 1'b1;
                div_num   <= y_num(idx + 1'b1, nr);
                div_den   <= DEN_W'(nr);
                div_start <= 1'b1;
                state     <= B_RING_YDIV;
              end
            end
          end
          default: state <= B_IDLE;
        endcase
      end
    end
  end

endmodule

/* rtl/smvg_front.sv */
`timescale 1ns / 1ps
// smvg_front: takes input words, classifies the patch, queues it
// depends on smvg_pkg; used by the top level
module smvg_front #(
  parameter int MAX_DIVISIONS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [smvg_pkg::IDX_W-1:0]    band,
  input  logic [smvg_pkg::IDX_W-1:0]    seg,
  input  logic [$clog2(MAX_DIVISIONS+1)-1:0] nr,
  input  logic [$clog2(MAX_DIVISIONS+1)-1:0] ns,
  input  logic                          hold,
  output logic                          q_valid,
  output smvg_pkg::patch_t              q_item,
  input  logic                          q_pop
);

  localparam int PW = smvg_pkg::Q_PTR_W;

  smvg_pkg::patch_t slots [smvg_pkg::Q_DEPTH];
  logic [PW-1:0]    wp, rp;
  logic [PW:0]      count;
  logic             accept;
  smvg_pkg::patch_t item;

  always_comb begin
    item.band = band;
    item.seg  = seg;
    if (32'(band) >= 32'(nr) || 32'(seg) >= 32'(ns)) begin
      item.kind = smvg_pkg::KIND_BAD;
    end else if (band == '0) begin
      item.kind = smvg_pkg::KIND_TOP;
    end else if (32'(band) + 32'd1 == 32'(nr)) begin
      item.kind = smvg_pkg::KIND_BOTTOM;
    end else begin
      item.kind = smvg_pkg::KIND_MIDDLE;
    end
  end

  assign in_ready = (count != (PW+1)'(smvg_pkg::Q_DEPTH)) && !hold;
  assign accept   = in_valid && in_ready;
  assign q_valid  = count != '0;
  assign q_item   = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (accept) wp <= wp + 1'b1;
      if (q_pop)  rp <= rp + 1'b1;
      case ({accept, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) slots[wp] <= item;
  end

endmodule

/* rtl/smvg_back.sv */
`timescale 1ns / 1ps
// smvg_back: expands queued patches into vertices and computes each vertex
// depends on smvg_pkg; holds the trig and ring tables; used by the top level
module smvg_back #(
  parameter int MAX_DIVISIONS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  smvg_pkg::patch_t                    q_item,
  output logic                                q_pop,
  input  logic [$clog2(MAX_DIVISIONS+1)-1:0]  nr,
  input  logic [smvg_pkg::RADIUS_W-1:0]       radius,
  input  smvg_pkg::tbl_wr_t                   wr,
  input  logic [$clog2(MAX_DIVISIONS+1)-1:0]  wr_addr,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [smvg_pkg::POS_W-1:0]   pos_x,
  output logic signed [smvg_pkg::POS_W-1:0]   pos_y,
  output logic signed [smvg_pkg::POS_W-1:0]   pos_z,
  output logic signed [smvg_pkg::NORM_W-1:0]  norm_x,
  output logic signed [smvg_pkg::NORM_W-1:0]  norm_y,
  output logic signed [smvg_pkg::NORM_W-1:0]  norm_z,
  output logic                                last_vertex,
  output logic                                bad_index
);

  localparam int CW    = $clog2(MAX_DIVISIONS+1);
  localparam int DEPTH = MAX_DIVISIONS + 1;
  localparam int TW    = smvg_pkg::TRIG_W;
  localparam int RW    = smvg_pkg::RAD_W;
  localparam int PRW   = 2*TW;
  localparam int PMW   = smvg_pkg::RADIUS_W + 1 + TW;
  localparam int PW    = smvg_pkg::POS_W;
  localparam int NW    = smvg_pkg::NORM_W;
  localparam logic signed [PRW-1:0] RND30_P = PRW'(64'sd536870912);
  localparam logic signed [PMW-1:0] RND30_M = PMW'(64'sd536870912);

  // tables
  logic signed [TW-1:0] seg_co_mem  [DEPTH];
  logic signed [TW-1:0] seg_si_mem  [DEPTH];
  logic signed [TW-1:0] ring_uy_mem [DEPTH];
  logic [RW-1:0]        ring_r_mem  [DEPTH];

  logic       adv, issue, v_last;
  logic [2:0] vcnt, nverts;
  logic [CW-1:0] ring_sel, seg_sel, b0, b1, j0, j1, nm1;
  logic       last_sel, bad_sel;

  // stage 1: table read
  logic                 v1, l1, e1;
  logic signed [TW-1:0] co1, si1, uy1;
  logic [RW-1:0]        r1;
  // stage 2: products
  logic                  v2, l2, e2;
  logic signed [PRW-1:0] px2, pz2;
  logic signed [TW-1:0]  uy2;
  // stage 3: unit point
  logic                 v3, l3, e3;
  logic signed [TW-1:0] u3 [3];
  logic signed [PRW-1:0] rx, rz;
  // stage 4: scaled position and normal
  logic                  v4, l4, e4;
  logic signed [PMW-1:0] pm4 [3];
  logic signed [NW-1:0]  n4 [3];
  // output register
  logic signed [PW-1:0] pos_q [3];
  logic signed [NW-1:0] nrm_q [3];

  function automatic logic signed [NW-1:0] to_norm(input logic signed [TW-1:0] u);
    logic signed [TW-1:0] t;
    t = (u + TW'(32768)) >>> 16;
    if (t > TW'(16384))       return NW'(16384);
    else if (t < -TW'(16384)) return -NW'(16384);
    else                      return NW'(t);
  endfunction

  function automatic logic signed [PW-1:0] to_pos(input logic signed [PMW-1:0] p,
                                                 input logic lift);
    logic signed [PMW-1:0] t;
    t = ((p + RND30_M) >>> 30) + (lift ? PMW'(smvg_pkg::LIFT_Q8) : PMW'(0));
    if (t > PMW'(131071))       return PW'(131071);
    else if (t < -PMW'(131072)) return PW'(-131072);
    else                        return PW'(t);
  endfunction

  assign adv    = !out_valid || out_ready;
  assign issue  = adv && q_valid;
  assign v_last = vcnt == nverts - 3'd1;
  assign q_pop  = issue && v_last;

  assign b0  = CW'(q_item.band);
  assign b1  = b0 + 1'b1;
  assign j0  = CW'(q_item.seg);
  assign j1  = j0 + 1'b1;
  assign nm1 = nr - 1'b1;

  // vertex list of each patch kind
  always_comb begin
    ring_sel = '0;
    seg_sel  = '0;
    last_sel = 1'b0;
    bad_sel  = 1'b0;
    nverts   = 3'd6;
    case (q_item.kind)
      smvg_pkg::KIND_BAD: begin
        nverts  = 3'd1;
        bad_sel = 1'b1;
      end
      smvg_pkg::KIND_TOP: begin
        nverts = 3'd3;
        case (vcnt)
          3'd0:    begin ring_sel = '0; seg_sel = '0; end
          3'd1:    begin ring_sel = CW'(1); seg_sel = j1; end
          default: begin ring_sel = CW'(1); seg_sel = j0; last_sel = 1'b1; end
        endcase
      end
      smvg_pkg::KIND_BOTTOM: begin
        nverts = 3'd3;
        case (vcnt)
          3'd0:    begin ring_sel = nr;  seg_sel = '0; end
          3'd1:    begin ring_sel = nm1; seg_sel = j0; end
          default: begin ring_sel = nm1; seg_sel = j1; last_sel = 1'b1; end
        endcase
      end
      default: begin
        case (vcnt)
          3'd0:    begin ring_sel = b0; seg_sel = j0; end
          3'd1:    begin ring_sel = b0; seg_sel = j1; end
          3'd2:    begin ring_sel = b1; seg_sel = j1; end
          3'd3:    begin ring_sel = b0; seg_sel = j0; end
          3'd4:    begin ring_sel = b1; seg_sel = j1; end
          default: begin ring_sel = b1; seg_sel = j0; last_sel = 1'b1; end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.seg_we) begin
      seg_co_mem[wr_addr] <= wr.co;
      seg_si_mem[wr_addr] <= wr.si;
    end
    if (wr.ring_we) begin
      ring_uy_mem[wr_addr] <= wr.uy;
      ring_r_mem[wr_addr]  <= wr.r;
    end
    if (adv) begin
      co1 <= seg_co_mem[seg_sel];
      si1 <= seg_si_mem[seg_sel];
      uy1 <= ring_uy_mem[ring_sel];
      r1  <= ring_r_mem[ring_sel];
    end
  end

  // control flags of the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt      <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) vcnt <= v_last ? 3'd0 : vcnt + 3'd1;
      if (adv) begin
        v1        <= issue;
        v2        <= v1;
        v3        <= v2;
        v4        <= v3;
        out_valid <= v4;
      end
    end
  end

  assign rx = (px2 + RND30_P) >>> 30;
  assign rz = (pz2 + RND30_P) >>> 30;

  always_ff @(posedge clk) begin
    if (adv) begin
      l1 <= last_sel;
      e1 <= bad_sel;

      l2  <= l1;
      e2  <= e1;
      px2 <= $signed({1'b0, r1}) * co1;
      pz2 <= $signed({1'b0, r1}) * si1;
      uy2 <= uy1;

      l3    <= l2;
      e3    <= e2;
      u3[0] <= TW'(rx);
      u3[1] <= uy2;
      u3[2] <= -TW'(rz);

      l4 <= l3;
      e4 <= e3;
      for (int m = 0; m < 3; m++) begin
        pm4[m] <= $signed({1'b0, radius}) * u3[m];
        n4[m]  <= to_norm(u3[m]);
      end

      last_vertex <= l4;
      bad_index   <= e4;
      for (int m = 0; m < 3; m++) begin
        pos_q[m] <= e4 ? '0 : to_pos(pm4[m], m == 1);
        nrm_q[m] <= e4 ? '0 : n4[m];
      end
    end
  end

  assign pos_x  = pos_q[0];
  assign pos_y  = pos_q[1];
  assign pos_z  = pos_q[2];
  assign norm_x = nrm_q[0];
  assign norm_y = nrm_q[1];
  assign norm_z = nrm_q[2];

endmodule

/* bench/sphere_mesh_vertex_generator_test.sv */
`timescale 1ns / 1ps
// sphere_mesh_vertex_generator_test: self-checking bench for the sphere patch vertex generator
// depends on smvg_pkg and sphere_mesh_vertex_generator; predicts every vertex word in fixed point
module sphere_mesh_vertex_generator_test;

  localparam int MAX_DIV   = 64;
  localparam int WATCHDOG  = 60000;  // covers a full table rebuild at 64 x 64 plus stalls
  localparam int DRAIN_GAP = 20;     // quiet cycles after the last expected word
  localparam int PW        = smvg_pkg::POS_W;
  localparam int NW        = smvg_pkg::NORM_W;
  localparam int AW        = smvg_pkg::CFG_ADDR_W;
  localparam int DW        = smvg_pkg::CFG_DATA_W;
  localparam int STEPS     = smvg_pkg::CORDIC_STEPS;

  typedef struct packed {
    logic signed [PW-1:0] px, py, pz;
    logic signed [NW-1:0] nx, ny, nz;
    logic                 last;
    logic                 bad;
  } vertex_t;

  // vertex predictor plus the queue of vertices still owed by the block
  class vertex_scoreboard;
    int unsigned segments = 10, bands = 10, radius = 256;
    vertex_t     owed[$];
    int          errors = 0, n_vert = 0, n_bad = 0, n_patch = 0;
    longint      atan_q[STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087,
      667544, 333772, 166886, 83443, 41722,
      20861, 10430, 5215, 2608, 1304};

    function void set_reg(logic [AW-1:0] idx, int unsigned val);
      case (idx)
        smvg_pkg::REG_SEGMENT_COUNT: segments = val & 'h7f;
        smvg_pkg::REG_BAND_COUNT:    bands    = val & 'h7f;
        smvg_pkg::REG_SPHERE_RADIUS: radius   = val & 'hffff;
        default: ;
      endcase
    endfunction

    function longint round_shift(longint v, int k);
      return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, bit_q;
      res = 0;
      bit_q = 64'd1 << 62;
      while (bit_q > v) bit_q >>= 2;
      while (bit_q != 0) begin
        if (v >= res + bit_q) begin
          v -= res + bit_q;
          res = (res >> 1) + bit_q;
        end else begin
          res >>= 1;
        end
        bit_q >>= 2;
      end
      return res;
    endfunction

    // rotator over the low 30 phase bits, quadrant from the top two
    function void trig(int unsigned j, int unsigned ns, output longint co, output longint si);
      longint unsigned ph;
      longint          x, y, z, nx;
      ph = (((longint'(j)) << 32) + ns / 2) / ns;
      ph &= 64'hffff_ffff;
      z = ph & 64'h3fff_ffff;
      x = 652032874;
      y = 0;
      for (int k = 0; k < STEPS; k++) begin
        if (z >= 0) begin
          nx = x - (y >>> k);
          y  = y + (x >>> k);
          z -= atan_q[k];
        end else begin
          nx = x + (y >>> k);
          y  = y - (x >>> k);
          z += atan_q[k];
        end
        x = nx;
      end
      case (ph[31:30])
        2'd0: begin co = x;  si = y;  end
        2'd1: begin co = -y; si = x;  end
        2'd2: begin co = -x; si = -y; end
        default: begin co = y; si = -x; end
      endcase
    endfunction

    function vertex_t vertex(int unsigned ring, int unsigned seg, int unsigned nr,
                             int unsigned ns, bit last);
      vertex_t         v;
      longint          d, ym, r, co, si, p, n;
      longint          u[3];
      longint unsigned q, t;
      d  = longint'(nr) - 2 * longint'(ring);
      ym = ((d < 0 ? -d : d) << 30) / nr;
      q  = 4 * longint'(ring) * longint'(nr - ring);
      t  = (q << 46) / (longint'(nr) * nr);
      r  = root(t << 14);
      trig(seg, ns, co, si);
      u[0] = round_shift(r * co, 30);
      u[1] = d < 0 ? -ym : ym;
      u[2] = -round_shift(r * si, 30);
      v = '0;
      for (int m = 0; m < 3; m++) begin
        p = clip(round_shift(longint'(radius) * u[m], 30) + (m == 1 ? smvg_pkg::LIFT_Q8 : 0),
                 -131072, 131071);
        n = clip(round_shift(u[m], 16), -16384, 16384);
        case (m)
          0: begin v.px = PW'(p); v.nx = NW'(n); end
          1: begin v.py = PW'(p); v.ny = NW'(n); end
          default: begin v.pz = PW'(p); v.nz = NW'(n); end
        endcase
      end
      v.last = last;
      return v;
    endfunction

    // append one vertex at the tail of the owed list
    function void owe(vertex_t v);
      owed.insert(owed.size(), v);
    endfunction

    // an accepted patch word: queue its vertices in output order
    function void note_patch(int unsigned b, int unsigned j);
      int unsigned nr, ns;
      vertex_t     v;
      nr = bands > MAX_DIV ? MAX_DIV : bands;
      ns = segments > MAX_DIV ? MAX_DIV : segments;
      n_patch++;
      if (b >= nr || j >= ns) begin
        v = '0;
        v.bad = 1'b1;
        owe(v);
      end else if (b == 0) begin
        owe(vertex(0, 0, nr, ns, 0));
        owe(vertex(1, j + 1, nr, ns, 0));
        owe(vertex(1, j, nr, ns, 1));
      end else if (b == nr - 1) begin
        owe(vertex(nr, 0, nr, ns, 0));
        owe(vertex(nr - 1, j, nr, ns, 0));
        owe(vertex(nr - 1, j + 1, nr, ns, 1));
      end else begin
        owe(vertex(b, j, nr, ns, 0));
        owe(vertex(b, j + 1, nr, ns, 0));
        owe(vertex(b + 1, j + 1, nr, ns, 0));
        owe(vertex(b, j, nr, ns, 0));
        owe(vertex(b + 1, j + 1, nr, ns, 0));
        owe(vertex(b + 1, j, nr, ns, 1));
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex word px=%0d py=%0d pz=%0d bad=%0b",
                 $time, got.px, got.py, got.pz, got.bad);
        return;
      end
      want = owed.pop_front();
      if (got.bad) n_bad++; else n_vert++;
      if (got !== want) begin
        errors++;
        $display("%0t: vertex mismatch expected p=(%0d %0d %0d) n=(%0d %0d %0d) last=%0b bad=%0b",
                 $time, want.px, want.py, want.pz, want.nx, want.ny, want.nz,
                 want.last, want.bad);
        $display("%0t:                 actual p=(%0d %0d %0d) n=(%0d %0d %0d) last=%0b bad=%0b",
                 $time, got.px, got.py, got.pz, got.nx, got.ny, got.nz, got.last, got.bad);
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [15:0]   s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [103:0]  m_tdata;
  logic          m_tlast;
  logic          m_tuser;
  logic          cfg_we = 1'b0;
  logic [AW-1:0] cfg_index = '0;
  logic [DW-1:0] cfg_data = '0;

  vertex_scoreboard sb = new();
  int               gap_pct = 0;    // sender idle chance per word
  int               stall_pct = 0;  // receiver stall chance per cycle
  int               quiet = 0;

  sphere_mesh_vertex_generator #(.MAX_DIVISIONS(MAX_DIV)) DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .m_tlast, .m_tuser, .cfg_we, .cfg_index, .cfg_data);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random backpressure at the falling edge
  always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= stall_pct);

  // result monitor, tdata unpacked from bit 0 up
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_vertex({m_tdata[17:0], m_tdata[35:18], m_tdata[53:36], m_tdata[69:54],
                       m_tdata[85:70], m_tdata[101:86], m_tlast, m_tuser});
  end

  // watchdog: cycles with no word moving on either channel and no register write
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("%0t: watchdog expired with %0d vertices owed", $time, sb.owed.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // s_tvalid is only lowered in a gap, so back-to-back words never toggle it in one step
  task automatic send_patch(int unsigned b, int unsigned j);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, j[5:0], b[5:0]};
    do @(posedge clk); while (!s_tready);
    sb.note_patch(b, j);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_reg(logic [AW-1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= DW'(val);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // mostly in-range patches, some arbitrary indices for the bad-index path
  task automatic random_patches(int count);
    int unsigned nr, ns;
    nr = sb.bands > MAX_DIV ? MAX_DIV : sb.bands;
    ns = sb.segments > MAX_DIV ? MAX_DIV : sb.segments;
    for (int i = 0; i < count; i++) begin
      if (nr > 0 && ns > 0 && $urandom_range(0, 99) < 85)
        send_patch($urandom_range(0, nr - 1), $urandom_range(0, ns - 1));
      else
        send_patch($urandom_range(0, 63), $urandom_range(0, 63));
      // hold off once until everything owed has come out
      if (i == count / 2 && gap_pct == 88) drain();
    end
  endtask

  int unsigned cfg_seg[8] = '{10, 3, 64, 127, 1, 2, 0, 17};
  int unsigned cfg_band[8] = '{10, 2, 64, 127, 1, 3, 5, 0};
  int unsigned cfg_rad[8] = '{256, 0, 65535, 1000, 300, 777, 256, 40000};

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed at reset settings: caps, middle, seam wrap, out of range, field extremes
    send_patch(0, 0);
    send_patch(0, 9);
    send_patch(9, 9);
    send_patch(9, 0);
    send_patch(5, 3);
    send_patch(1, 9);
    send_patch(8, 0);
    send_patch(10, 0);
    send_patch(0, 10);
    send_patch(63, 63);
    send_patch(63, 0);
    send_patch(0, 63);
    send_patch(42, 21);
    drain();

    for (int c = 0; c < 8; c++) begin
      write_reg(smvg_pkg::REG_SEGMENT_COUNT, cfg_seg[c]);
      write_reg(smvg_pkg::REG_BAND_COUNT, cfg_band[c]);
      write_reg(smvg_pkg::REG_SPHERE_RADIUS, cfg_rad[c]);
      send_patch(0, 0);
      send_patch(cfg_band[c] > 0 ? (cfg_band[c] > MAX_DIV ? MAX_DIV - 1 : cfg_band[c] - 1) : 0,
                 cfg_seg[c] > 0 ? (cfg_seg[c] > MAX_DIV ? MAX_DIV - 1 : cfg_seg[c] - 1) : 0);
      for (int ph = 0; ph < 4; ph++) begin
        gap_pct   = (ph == 1) ? 88 : (ph == 3 ? 23 : 0);
        stall_pct = (ph == 2) ? 88 : (ph == 3 ? 23 : 0);
        random_patches(11);
      end
      gap_pct = 0;
      stall_pct = 0;
      drain();
    end

    $display("covered %0d patch words: %0d vertices and %0d bad-index words", sb.n_patch,
             sb.n_vert, sb.n_bad);
    $display("over 9 register settings incl. zero, one, saturated counts and radius extremes");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sphere_mesh_vertex_generator.f */
rtl/smvg_pkg.sv
rtl/smvg_div.sv
rtl/smvg_isqrt.sv
rtl/smvg_build.sv
rtl/smvg_front.sv
rtl/smvg_back.sv
rtl/sphere_mesh_vertex_generator.sv
bench/sphere_mesh_vertex_generator_test.sv
